@@ rtl/core/tuner_pll_register_sequencer_macros.svh @@
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef TUNER_PLL_REGISTER_SEQUENCER_MACROS_SVH
`define TUNER_PLL_REGISTER_SEQUENCER_MACROS_SVH

// same-cycle implication
`define TPRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tprs_pkg.sv @@
package tprs_pkg;

  typedef struct packed {
    logic [21:0] lo_freq;
    logic [25:0] bw_hz;
  } tprs_in_t;

  typedef struct packed {
    logic [2:0] write_len;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [7:0] data3;
    logic       last_write;
  } tprs_out_t;

  // the four pll register bytes after one request is worked out
  typedef struct packed {
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
  } tprs_regs_t;

  typedef enum logic [3:0] {
    GRP_PLL   = 4'b0001,
    GRP_PUMP  = 4'b0010,
    GRP_CTRL  = 4'b0100,
    GRP_FINAL = 4'b1000
  } tprs_grp_e;

  localparam logic [21:0] FREQ_MAX_KHZ = 22'd2150000;
  localparam logic [25:0] BW_MAX_HZ    = 26'd50000000;

  localparam int unsigned NUM_BANDS = 9;
  localparam logic [21:0] BAND_LO [NUM_BANDS] = '{
    22'd0, 22'd986000, 22'd1073000, 22'd1154000, 22'd1291000,
    22'd1447000, 22'd1615000, 22'd1791000, 22'd1972000
  };
  localparam logic [2:0] BAND_BA [NUM_BANDS] = '{
    3'd5, 3'd6, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
  };
  localparam logic BAND_DIV [NUM_BANDS] = '{
    1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  localparam logic [21:0] FREQ_HALF_STEP = 22'd1024000;
  localparam logic [21:0] FREQ_CP_SPLIT  = 22'd1450000;
  localparam logic [21:0] FREQ_CP_LO_A   = 22'd1300000;
  localparam logic [21:0] FREQ_CP_LO_B   = 22'd1375000;
  localparam logic [21:0] FREQ_CP_HI_A   = 22'd1850000;
  localparam logic [21:0] FREQ_CP_HI_B   = 22'd2045000;

  // ceil(2^27 / 125): exact quotient for any 20-bit dividend
  localparam logic [20:0] RECIP_125  = 21'd1073742;
  localparam int unsigned RECIP_SHIFT = 27;

  localparam logic [25:0] BW_MIN_HZ = 26'd1000;

  localparam logic [2:0] LEN_FOUR = 3'd4;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_ONE  = 3'd1;

endpackage

@@ rtl/core/tprs_calc.sv @@
module tprs_calc (
  input  tprs_pkg::tprs_in_t   req_i,
  output tprs_pkg::tprs_regs_t regs_o
);
  import tprs_pkg::*;

  function automatic logic [3:0] lpf_code(input logic [25:0] bw);
    if (bw >= 26'd32001000) return 4'd15;
    if (bw >= 26'd30001000) return 4'd14;
    if (bw >= 26'd28001000) return 4'd13;
    if (bw >= 26'd26001000) return 4'd12;
    if (bw >= 26'd24001000) return 4'd11;
    if (bw >= 26'd22001000) return 4'd10;
    if (bw >= 26'd20001000) return 4'd9;
    if (bw >= 26'd18001000) return 4'd8;
    if (bw >= 26'd16001000) return 4'd7;
    if (bw >= 26'd12001000) return 4'd6;
    if (bw >= 26'd8001000)  return 4'd5;
    if (bw >= 26'd6001000)  return 4'd4;
    return 4'd3;
  endfunction

  logic [21:0] f;
  logic [25:0] bw;
  logic [3:0]  band;
  logic        psc;
  logic        half_step;
  logic        cp_bit6;
  logic        cp_bit5;
  logic [21:0] rnd;
  logic [19:0] y;
  logic [40:0] prod;
  logic [11:0] cnt;
  logic [12:0] word;
  logic [3:0]  lpf;

  assign f  = (req_i.lo_freq > FREQ_MAX_KHZ) ? FREQ_MAX_KHZ : req_i.lo_freq;
  assign bw = (req_i.bw_hz > BW_MAX_HZ) ? BW_MAX_HZ : req_i.bw_hz;

  // highest band whose lower edge is reached
  always_comb begin
    band = '0;
    for (int i = 1; i < NUM_BANDS; i++) begin
      if (f >= BAND_LO[i]) band = 4'(i);
    end
  end

  assign psc       = (band < 4'd2);
  assign half_step = (f < FREQ_HALF_STEP);

  always_comb begin
    cp_bit6 = 1'b1;
    cp_bit5 = 1'b1;
    if (f < FREQ_CP_SPLIT) begin
      if (f < FREQ_CP_LO_A) cp_bit6 = 1'b0;
      else if (f < FREQ_CP_LO_B) cp_bit5 = 1'b0;
    end else begin
      if (f < FREQ_CP_HI_A) cp_bit6 = 1'b0;
      else if (f < FREQ_CP_HI_B) cp_bit5 = 1'b0;
    end
  end

  // rounded divide by 500 or 1000 kHz: pre-shift by 2 or 3 bits, then divide by 125
  assign rnd  = half_step ? (f + 22'd250) : (f + 22'd500);
  assign y    = half_step ? rnd[21:2] : {1'b0, rnd[21:3]};
  assign prod = 41'(y) * 41'(RECIP_125);
  assign cnt  = prod[RECIP_SHIFT +: 12];

  // program / swallow split on a prescaler of 16 or 32
  assign word = psc ? {cnt[11:4], 1'b0, cnt[3:0]} : {1'b0, cnt};

  assign lpf = (bw >= BW_MIN_HZ) ? lpf_code(bw) : 4'd0;

  assign regs_o.b1 = {3'b010, word[12:8]};
  assign regs_o.b2 = word[7:0];
  assign regs_o.b3 = {1'b1, cp_bit6, cp_bit5, lpf[0], lpf[1], 2'b00, half_step};
  assign regs_o.b4 = {BAND_BA[band], psc, lpf[2], lpf[3], BAND_DIV[band], 1'b0};

endmodule

@@ rtl/core/tprs_emitter.sv @@
module tprs_emitter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_valid_i,
  output logic                 load_ready_o,
  input  tprs_pkg::tprs_regs_t load_regs_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tprs_pkg::tprs_out_t  out_data_o
);
  import tprs_pkg::*;
  `include "tuner_pll_register_sequencer_macros.svh"

  tprs_regs_t bank_q;
  logic       bank_valid_q, bank_valid_d;
  tprs_grp_e  grp_q, grp_d;
  logic       take;
  logic       final_done;
  logic       load;

  assign take         = bank_valid_q && out_ready_i;
  assign final_done   = take && (grp_q == GRP_FINAL);
  assign load_ready_o = !bank_valid_q || final_done;
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    grp_d        = grp_q;
    bank_valid_d = bank_valid_q;
    if (load) begin
      grp_d        = GRP_PLL;
      bank_valid_d = 1'b1;
    end else if (take) begin
      case (grp_q)
        GRP_PLL:   grp_d = GRP_PUMP;
        GRP_PUMP:  grp_d = GRP_CTRL;
        GRP_CTRL:  grp_d = GRP_FINAL;
        GRP_FINAL: begin
          grp_d        = GRP_PLL;
          bank_valid_d = 1'b0;
        end
        default:   grp_d = GRP_PLL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_valid_q <= 1'b0;
      grp_q        <= GRP_PLL;
    end else begin
      bank_valid_q <= bank_valid_d;
      grp_q        <= grp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) bank_q <= load_regs_i;
  end

  always_comb begin
    out_data_o = '0;
    case (grp_q)
      GRP_PLL: begin
        out_data_o.write_len = LEN_FOUR;
        out_data_o.data0     = {3'b001, bank_q.b1[4:0]};
        out_data_o.data1     = bank_q.b2;
        out_data_o.data2     = bank_q.b3 & 8'hE3;
        out_data_o.data3     = bank_q.b4 & 8'hF3;
      end
      GRP_PUMP: begin
        // charge pump on with the filter bits masked
        out_data_o.write_len = LEN_ONE;
        out_data_o.data0     = (bank_q.b3 & 8'hE3) | 8'h04;
      end
      GRP_CTRL: begin
        out_data_o.write_len = LEN_TWO;
        out_data_o.data0     = bank_q.b3 | 8'h04;
        out_data_o.data1     = bank_q.b4;
      end
      GRP_FINAL: begin
        out_data_o.write_len  = LEN_ONE;
        out_data_o.data0      = bank_q.b1;
        out_data_o.last_write = 1'b1;
      end
      default: out_data_o = '0;
    endcase
  end

  assign out_valid_o = bank_valid_q;

  `TPRS_ASSERT_NOW(a_load_when_free, load, !bank_valid_q || final_done,
                   "request loaded over a bank still in use")
  `TPRS_ASSERT_NEXT(a_load_starts, load, out_valid_o && grp_q == GRP_PLL,
                    "loaded request does not start at the first group")
  `TPRS_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i,
                    $stable(grp_q) && out_valid_o, "group moved while stalled")
  `TPRS_ASSERT_NEXT(a_drain, final_done && !load_valid_i, !out_valid_o,
                    "bank still valid after the final group")

endmodule

@@ rtl/core/tuner_pll_register_sequencer.sv @@
// path: an accepted request is registered in the input register, then loaded into the
//   emitter bank, which drives the first write group; a busy bank holds off the load
// throughput: one write group per cycle while out_ready_i is high, set by the
//   four-group output sequencer; a new request is held in the input register meanwhile
// reset: asynchronous active low, clears valid flags and the group sequencer;
//   no write groups are pending after reset
module tuner_pll_register_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tprs_pkg::tprs_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tprs_pkg::tprs_out_t out_data_o
);
  import tprs_pkg::*;

  logic       in_valid_q, in_valid_d;
  tprs_in_t   in_q;
  tprs_regs_t regs;
  logic       load_ready;
  logic       load;
  logic       accept;

  assign load       = in_valid_q && load_ready;
  assign in_ready_o = !in_valid_q || load_ready;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) in_valid_d = 1'b1;
    else if (load) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
  end

  tprs_calc u_calc (
    .req_i  (in_q),
    .regs_o (regs)
  );

  tprs_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (in_valid_q),
    .load_ready_o (load_ready),
    .load_regs_i  (regs),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
